// File: sv/lru_kvc_pkg.sv
// Package for the LRU key/value cache: sizes, operation codes and the
// request/response structs shared by the interfaces and the modules.
// No dependencies.
package lru_kvc_pkg;

    // Number of slots in the store
    localparam int ENTRIES = 16;

    // Widths of the fixed fields
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    // Rank and fill-count widths follow the slot count
    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    // Width used to compare the fill count against the capacity register
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Operation codes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Value returned by a lookup miss
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

    typedef struct packed {
        logic                     operation;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } lru_kvc_req_t;

    typedef struct packed {
        logic                     found;
        logic signed [DATA_W-1:0] read_value;
    } lru_kvc_rsp_t;

endpackage

// File: sv/lru_kvc_if.sv
// Valid/ready channel interfaces of the LRU key/value cache: request,
// response and capacity configuration. Depends on lru_kvc_pkg.

// Request channel: operation, key, value
interface lru_kvc_req_if import lru_kvc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output operation, output key, output value,
                    input ready);
    modport sink   (input valid, input operation, input key, input value,
                    output ready);
endinterface

// Response channel: found flag and read value
interface lru_kvc_rsp_if import lru_kvc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     found;
    logic signed [DATA_W-1:0] read_value;

    modport source (output valid, output found, output read_value, input ready);
    modport sink   (input valid, input found, input read_value, output ready);
endinterface

// Configuration channel: capacity register write data
interface lru_kvc_cfg_if import lru_kvc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/lru_kvc_store.sv
// Slot store of the LRU key/value cache: key/value registers, valid bits,
// recency ranks and fill count, with the combinational lookup and the registered update.
// Depends on lru_kvc_pkg.
module lru_kvc_store import lru_kvc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             commit,
    input  lru_kvc_req_t     req,
    input  logic [CAP_W-1:0] capacity,
    output lru_kvc_rsp_t     rsp
);

    // Slot contents (no reset: only read where the valid bit is set)
    logic [DATA_W-1:0] key_reg [ENTRIES];
    logic [DATA_W-1:0] val_reg [ENTRIES];

    // Control state
    logic [ENTRIES-1:0] valid_reg;
    logic [RANK_W-1:0]  rank_reg [ENTRIES];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    logic [ENTRIES-1:0] hit_vec;
    logic [ENTRIES-1:0] lru_vec;
    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] tgt_vec;
    logic [DATA_W-1:0]  hit_val;
    logic [RANK_W-1:0]  hit_rank;
    logic [CNT_W-1:0]   count_m1;
    logic [CNT_W-1:0]   thr;
    logic [CMP_W-1:0]   cnt_ext;
    logic [CMP_W-1:0]   cap_ext;
    logic               hit;
    logic               full;
    logic               is_put;
    logic               insert;
    logic               upd;

    // Key compare and least-recent match across all slots.
    // Valid ranks always form 0..count-1, so the least recent slot is the
    // one whose rank equals count-1.
    assign count_m1 = count_reg - CNT_W'(1);

    always_comb
    begin
        hit_val  = '0;
        hit_rank = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i] = valid_reg[i] && (key_reg[i] == req.key);
            lru_vec[i] = valid_reg[i] && (CNT_W'(rank_reg[i]) == count_m1);
            hit_val    = hit_val  | (val_reg[i]  & {DATA_W{hit_vec[i]}});
            hit_rank   = hit_rank | (rank_reg[i] & {RANK_W{hit_vec[i]}});
        end
    end

    // Lowest-numbered free slot, one-hot
    assign free_vec = ~valid_reg & (valid_reg + ENTRIES'(1));

    assign hit = |hit_vec;

    // Full against the clamped capacity (zero counts as one)
    assign cnt_ext = CMP_W'(count_reg);
    assign cap_ext = CMP_W'(capacity);

    always_comb
    begin
        if (cnt_ext >= CMP_W'(ENTRIES))
            full = 1'b1;
        else if (capacity == '0)
            full = (count_reg != '0);
        else
            full = (cnt_ext >= cap_ext);
    end

    // Decide target slot and the rank threshold below which ranks age
    assign is_put = (req.operation == OP_PUT);
    assign insert = is_put && !hit && !full;
    assign upd    = commit && (hit || is_put);

    always_comb
    begin
        if (hit)
        begin
            tgt_vec = hit_vec;
            thr     = CNT_W'(hit_rank);
        end
        else if (full)
        begin
            tgt_vec = lru_vec;
            thr     = count_m1;
        end
        else
        begin
            tgt_vec = free_vec;
            thr     = count_reg;
        end
    end

    // Lookup result
    assign rsp.found      = hit;
    assign rsp.read_value = hit ? hit_val : MISS_VALUE;

    // Fill count
    assign count_next = (commit && insert) ? count_reg + CNT_W'(1) : count_reg;

    // Valid bits, ranks and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            count_reg <= count_next;
            if (upd)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (tgt_vec[i])
                    begin
                        rank_reg[i]  <= '0;
                        valid_reg[i] <= 1'b1;
                    end
                    else if (valid_reg[i] && (CNT_W'(rank_reg[i]) < thr))
                    begin
                        rank_reg[i] <= rank_reg[i] + RANK_W'(1);
                    end
                end
            end
        end
    end

    // Slot payload writes on put
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (commit && is_put && tgt_vec[i])
            begin
                key_reg[i] <= req.key;
                val_reg[i] <= req.value;
            end
        end
    end

endmodule

// File: sv/lru_key_value_cache_unit.sv
// Top level of the LRU key/value cache: request register, capacity register,
// response register and handshakes around the slot store.
// Depends on lru_kvc_pkg, lru_kvc_if and lru_kvc_store.
//
//  channel | modport | payload                        | transaction
//  --------+---------+--------------------------------+---------------------------
//  req     | sink    | operation, key, value          | get or put request
//  rsp     | source  | found, read_value              | one per get, none per put
//  cfg     | sink    | data (capacity)                | capacity write, always ready
//
// One request per cycle while no get stalls. A request is registered, then
// looked up and applied to the store as it leaves the request register; a
// get result is then written into the response register. req.ready falls
// only while a get sits in the request register and the response register
// holds an untaken result. Reset clears all slots and sets capacity to 16.
module lru_key_value_cache_unit import lru_kvc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    lru_kvc_cfg_if.sink   cfg,
    lru_kvc_req_if.sink   req,
    lru_kvc_rsp_if.source rsp
);

    logic [CAP_W-1:0] cap_reg;
    logic             req_vld_reg;
    lru_kvc_req_t     req_reg;
    logic             rsp_vld_reg;
    logic             rsp_vld_next;
    lru_kvc_rsp_t     rsp_reg;
    lru_kvc_rsp_t     lookup;
    logic             advance;
    logic             is_get;

    // Capacity register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (cfg.valid)
            cap_reg <= cfg.data;
    end

    // Stage advance: puts never wait, gets need room in the response register
    assign is_get    = (req_reg.operation == OP_GET);
    assign advance   = req_vld_reg && (!is_get || !rsp_vld_reg || rsp.ready);
    assign req.ready = !req_vld_reg || advance;

    // Request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_vld_reg <= 1'b0;
        else if (req.ready)
            req_vld_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            req_reg.operation <= req.operation;
            req_reg.key       <= req.key;
            req_reg.value     <= req.value;
        end
    end

    // Slot store
    lru_kvc_store u_store
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .commit   (advance),
        .req      (req_reg),
        .capacity (cap_reg),
        .rsp      (lookup)
    );

    // Response register
    always_comb
    begin
        if (advance && is_get)
            rsp_vld_next = 1'b1;
        else if (rsp.ready)
            rsp_vld_next = 1'b0;
        else
            rsp_vld_next = rsp_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_vld_reg <= 1'b0;
        else
            rsp_vld_reg <= rsp_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_get)
            rsp_reg <= lookup;
    end

    assign rsp.valid      = rsp_vld_reg;
    assign rsp.found      = rsp_reg.found;
    assign rsp.read_value = rsp_reg.read_value;

`ifndef NO_ASSERTIONS
    // A miss always returns all ones
    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_vld_reg && !rsp_reg.found |-> rsp_reg.read_value == MISS_VALUE)
        else $error("miss response without all-ones value");

    // A get that leaves the request register shows up as a response
    a_get_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_get |=> rsp_vld_reg)
        else $error("get lost on its way to the response register");

    // Back-pressure only from a get blocked behind an untaken response
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> req_vld_reg && is_get && rsp_vld_reg && !rsp.ready)
        else $error("request stalled without cause");

    // A put never creates a response
    a_put_silent: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !is_get && !rsp_vld_reg |=> !rsp_vld_reg)
        else $error("put produced a response");
`endif

endmodule
